[sv/marf_pkg.sv]
// ----------------------------------------------------------------------------
// marf_pkg - meter address rule filter shared definitions
// Widths, action codes, wildcard constants and the word that walks the cells.
// ----------------------------------------------------------------------------
package marf_pkg;

  localparam int unsigned MaxRulesDef = 16;

  localparam int unsigned IdxW    = 4;
  localparam int unsigned PlenW   = 4;
  localparam int unsigned IdW     = 32;
  localparam int unsigned MfctW   = 16;
  localparam int unsigned VerW    = 8;
  localparam int unsigned TypeW   = 8;
  localparam int unsigned CountW  = 5;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic [MfctW-1:0] AnyMfct     = 16'hffff;
  localparam logic [VerW-1:0]  AnyVersion  = 8'hff;
  localparam logic [TypeW-1:0] AnyType     = 8'hff;
  localparam logic [PlenW-1:0] ExactDigits = 4'd8;

  // Word handed from cell to cell: the item itself plus the running verdict.
  typedef struct packed {
    logic             action;
    logic [IdxW-1:0]  rule_index;
    logic             negate;
    logic [PlenW-1:0] prefix_len;
    logic [IdW-1:0]   id_value;
    logic [MfctW-1:0] mfct_code;
    logic [VerW-1:0]  version_code;
    logic [TypeW-1:0] dev_type;
    logic             pos_hit;
    logic             neg_hit;
    logic             exact_hit;
  } token_t;

endpackage

[sv/marf_if.sv]
// ----------------------------------------------------------------------------
// marf_item_if / marf_result_if - valid/ready channels of the rule filter
// Item channel carries load or query words, result channel the verdict.
// ----------------------------------------------------------------------------
interface marf_item_if;
  import marf_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [IdxW-1:0]  rule_index;
  logic             negate;
  logic [PlenW-1:0] prefix_len;
  logic [IdW-1:0]   id_value;
  logic [MfctW-1:0] mfct_code;
  logic [VerW-1:0]  version_code;
  logic [TypeW-1:0] dev_type;

  modport source (
    output valid, action, rule_index, negate, prefix_len, id_value,
           mfct_code, version_code, dev_type,
    input  ready
  );
  modport sink (
    input  valid, action, rule_index, negate, prefix_len, id_value,
           mfct_code, version_code, dev_type,
    output ready
  );
endinterface

interface marf_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic wild_only;

  modport source (output valid, matched, wild_only, input ready);
  modport sink   (input valid, matched, wild_only, output ready);
endinterface

[sv/meter_address_rule_filter_unit.sv]
// ----------------------------------------------------------------------------
// meter_address_rule_filter_unit - meter address rule filter
// Table of prefix/wildcard address rules checked by a row of rule cells.
// ----------------------------------------------------------------------------
// Every word, load or query, walks the row of MaxRules cells, one cell a
// cycle; cell k holds rule k. A load word is written by the cell whose index
// it names (an index past the table is dropped) and yields matched = 0,
// wild_only = 0. A query word collects hits from the first rule_count
// cells: any negative hit rejects, else any positive hit accepts, and
// wild_only flags an accept with no exact (eight digit) positive hit.
// One word is in the row at a time: a word walks the cell row, then waits in
// the hand-off stage until the output register is free, and its result then
// stands in the output register on the result channel; the next word is
// taken once the result is parked there, even if that result has not been
// taken yet. rule_count is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while no word is in flight, as the block does not enforce
// it. A rule never loaded but within rule_count gives an unspecified verdict.
// ----------------------------------------------------------------------------
module meter_address_rule_filter_unit #(
  parameter int unsigned MaxRules = marf_pkg::MaxRulesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [marf_pkg::CountW-1:0] cfg_wdata_i,
  marf_item_if.sink                   item_i,
  marf_result_if.source               result_o
);
  import marf_pkg::*;

  logic [CountW-1:0] rule_count_q;
  logic              busy_q;
  logic              accept;

  // Cell row links: index k feeds cell k.
  logic              vld_link [MaxRules+1];
  token_t            tok_link [MaxRules+1];

  // Hand-off stage between the row and the output register.
  logic              pend_vld_q;
  logic              pend_match_q, pend_wild_q;
  logic              out_vld_q;
  logic              out_match_q, out_wild_q;
  logic              out_free, move_out;
  logic              verdict_match, verdict_wild;

  // Hold the rule count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
    end else if (cfg_we_i) begin
      rule_count_q <= cfg_wdata_i;
    end
  end

  assign item_i.ready = !busy_q;
  assign accept       = item_i.valid && !busy_q;

  // Launch the word into the first cell with a clean verdict.
  assign vld_link[0]              = accept;
  assign tok_link[0].action       = item_i.action;
  assign tok_link[0].rule_index   = item_i.rule_index;
  assign tok_link[0].negate       = item_i.negate;
  assign tok_link[0].prefix_len   = item_i.prefix_len;
  assign tok_link[0].id_value     = item_i.id_value;
  assign tok_link[0].mfct_code    = item_i.mfct_code;
  assign tok_link[0].version_code = item_i.version_code;
  assign tok_link[0].dev_type     = item_i.dev_type;
  assign tok_link[0].pos_hit      = 1'b0;
  assign tok_link[0].neg_hit      = 1'b0;
  assign tok_link[0].exact_hit    = 1'b0;

  for (genvar k = 0; k < MaxRules; k++) begin : g_cell
    marf_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .rule_count_i (rule_count_q),
      .vld_i        (vld_link[k]),
      .tok_i        (tok_link[k]),
      .vld_o        (vld_link[k+1]),
      .tok_o        (tok_link[k+1])
    );
  end

  // Load words never set hit flags, so they fall out as a reject.
  assign verdict_match = tok_link[MaxRules].pos_hit && !tok_link[MaxRules].neg_hit;
  assign verdict_wild  = verdict_match && !tok_link[MaxRules].exact_hit;

  assign out_free = !out_vld_q || result_o.ready;
  assign move_out = pend_vld_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move_out) begin
        busy_q <= 1'b0;
      end
      if (vld_link[MaxRules]) begin
        pend_vld_q <= 1'b1;
      end else if (move_out) begin
        pend_vld_q <= 1'b0;
      end
      if (move_out) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_link[MaxRules]) begin
      pend_match_q <= verdict_match;
      pend_wild_q  <= verdict_wild;
    end
    if (move_out) begin
      out_match_q <= pend_match_q;
      out_wild_q  <= pend_wild_q;
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.matched   = out_match_q;
  assign result_o.wild_only = out_wild_q;

endmodule

[sv/marf_cell.sv]
// ----------------------------------------------------------------------------
// marf_cell - one rule of the filter table
// Holds one rule, writes it from a passing load word, folds its hit into a
// passing query word and hands the word on through its output register.
// ----------------------------------------------------------------------------
module marf_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [marf_pkg::CountW-1:0]  rule_count_i,
  input  logic                         vld_i,
  input  marf_pkg::token_t             tok_i,
  output logic                         vld_o,
  output marf_pkg::token_t             tok_o
);
  import marf_pkg::*;

  logic [IdW-1:0]   digits_q;
  logic [PlenW-1:0] prefix_q;
  logic             negative_q;
  logic [MfctW-1:0] mfct_q;
  logic [VerW-1:0]  version_q;
  logic [TypeW-1:0] devtype_q;

  logic             vld_q;
  token_t           tok_q, tok_d;
  logic             load_en, in_use, hit;
  logic [IdW-1:0]   mask;

  function automatic logic [IdW-1:0] digit_mask(input logic [PlenW-1:0] digits);
    logic [IdW-1:0] m;
    if (digits == '0) begin
      m = '0;
    end else if (digits >= ExactDigits) begin
      m = '1;
    end else begin
      m = ~({IdW{1'b1}} >> {digits, 2'b00});
    end
    return m;
  endfunction

  assign load_en = vld_i && (tok_i.action == ActLoad) &&
                   (32'(tok_i.rule_index) == CellIdx);

  // Rules beyond the count in use sit out of the query.
  assign in_use = 32'(rule_count_i) > CellIdx;
  assign mask   = digit_mask(prefix_q);

  assign hit = in_use && (tok_i.action == ActQuery) &&
               (mfct_q == AnyMfct || mfct_q == tok_i.mfct_code) &&
               (version_q == AnyVersion || version_q == tok_i.version_code) &&
               (devtype_q == AnyType || devtype_q == tok_i.dev_type) &&
               (((digits_q ^ tok_i.id_value) & mask) == '0);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      if (negative_q) begin
        tok_d.neg_hit = 1'b1;
      end else begin
        tok_d.pos_hit = 1'b1;
        if (prefix_q >= ExactDigits) begin
          tok_d.exact_hit = 1'b1;
        end
      end
    end
  end

  // Rule storage: no reset, contents are defined once loaded.
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      digits_q   <= tok_i.id_value;
      prefix_q   <= (tok_i.prefix_len > ExactDigits) ? ExactDigits : tok_i.prefix_len;
      negative_q <= tok_i.negate;
      mfct_q     <= tok_i.mfct_code;
      version_q  <= tok_i.version_code;
      devtype_q  <= tok_i.dev_type;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

[sv/marf_checker.sv]
// ----------------------------------------------------------------------------
// marf_checker - port-level checks for the rule filter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module marf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic matched_i,
  input logic wild_only_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(matched_i) &&
                                    $stable(wild_only_i))
    else $error("result word changed while stalled");

  a_wild_implies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && wild_only_i |-> matched_i)
    else $error("wildcard flag without a match");

  // One word in the row at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while one is in flight");

  // A result needs the walk through the row.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared right after acceptance");

endmodule

bind meter_address_rule_filter_unit marf_checker u_marf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .matched_i   (result_o.matched),
  .wild_only_i (result_o.wild_only)
);
